// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// The expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// ----- hdl/crcbp_pkg.sv -----
// ----------------------------------------------------------------------------
// crcbp_pkg
// Constants, types and the CRC-8 byte step shared by the block framer.
// ----------------------------------------------------------------------------
package crcbp_pkg;

   localparam int            BYTE_W     = 8;
   localparam int            LANE_W     = 3;
   localparam int            WORD_W     = 64;
   localparam int            OUT_ADDR_W = 24;
   localparam int            RSP_PAD_W  = 7;
   localparam int            RSP_DATA_W = 104;
   localparam logic [7:0]    CRC_POLY   = 8'h07;
   localparam logic [7:0]    PAD_BYTE   = 8'hFF;

   typedef struct packed {
      logic       clear;
      logic       enable;
      logic [7:0] data;
   } crc_ctl_type;

   // One byte through the MSB-first CRC-8 shift register.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ----- hdl/crc8_block_packetizer.sv -----
// ----------------------------------------------------------------------------
// crc8_block_packetizer
// Cuts a byte stream into CRC-8 protected blocks of header plus data words.
// ----------------------------------------------------------------------------
// Image bytes enter on the req_ channel, one item per cycle while the block
// fills; req_tlast marks the final byte of the image. A block closes when it
// holds BLOCK_BYTES bytes or when the final byte arrives.
// On close, a short block first runs its 0xFF pad bytes through the CRC unit,
// one byte per cycle. The header item (rsp_tuser high) enters the output
// register once the block closes or the last pad byte is taken and the
// output register is free. (BLOCK_BYTES + 7) / 8 data words follow at one per
// cycle when not stalled, paced by the memory's registered read port.
// rsp_tlast marks the last word of each block; pad bytes are inserted as the
// words are read. req_tready stays low from the closing byte until the last
// word is loaded. A stalled receiver holds the output register; the read
// pipeline then stops and resumes without loss.
// Reset empties the current block, clears the CRC and sets the block address
// to zero. A block that ends the image also returns the address to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crc8_block_packetizer #(
   parameter int BLOCK_BYTES = 256,
   parameter int ADDR_BITS   = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // image_byte
   input  logic                             req_tlast,   // image_end
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // block_address [23:0], block_crc [31:24], payload_word [95:32],
   // image_done [96], zero fill [103:97]
   output logic [crcbp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                             rsp_tuser,   // is_header
   output logic                             rsp_tlast    // packet_end
);

   localparam int WORD_COUNT = (BLOCK_BYTES + 7) / 8;
   localparam int WA_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int WC_W       = $clog2(WORD_COUNT + 1);
   localparam int FILL_W     = $clog2(BLOCK_BYTES + 1);

   localparam logic [1:0] ST_FILL = 2'd0;
   localparam logic [1:0] ST_PAD  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]           state_ff,    state_in;
   logic [FILL_W-1:0]    fill_ff,     fill_in;
   logic [FILL_W-1:0]    pad_ff,      pad_in;
   logic [ADDR_BITS-1:0] addr_ff,     addr_in;
   logic                 last_ff,     last_in;
   logic                 hdr_pend_ff, hdr_pend_in;
   logic [WC_W-1:0]      rd_cnt_ff,   rd_cnt_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [WC_W-1:0]      ld_cnt_ff,   ld_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hdr_ff,  rsp_hdr_in;
   logic [crcbp_pkg::OUT_ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [7:0]           rsp_crc_ff,  rsp_crc_in;
   logic [crcbp_pkg::WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic                 rsp_end_ff,  rsp_end_in;
   logic                 rsp_done_ff, rsp_done_in;

   logic                 accept;
   logic [FILL_W-1:0]    fill_inc;
   logic                 out_free;
   logic                 load_hdr;
   logic                 load_word;
   logic                 issue_rd;
   logic                 last_word;
   logic                 done_blk;
   logic [31:0]          addr_ext;
   logic [7:0]           crc_value;
   logic [crcbp_pkg::WORD_W-1:0] rd_data;
   logic [crcbp_pkg::WORD_W-1:0] word_masked;
   crcbp_pkg::crc_ctl_type crc_ctl;

   assign req_tready = (state_ff == ST_FILL);
   assign accept     = req_tvalid && req_tready;
   assign fill_inc   = fill_ff + FILL_W'(1);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign load_hdr   = (state_ff == ST_EMIT) && hdr_pend_ff && out_free;
   assign load_word  = (state_ff == ST_EMIT) && !hdr_pend_ff && rd_valid_ff && out_free;
   assign issue_rd   = (state_ff == ST_EMIT) && (rd_cnt_ff != WC_W'(WORD_COUNT))
                       && (!rd_valid_ff || load_word);
   assign last_word  = (ld_cnt_ff == WC_W'(WORD_COUNT - 1));
   assign done_blk   = load_word && last_word;
   assign addr_ext   = 32'(addr_ff);

   always_comb begin
      crc_ctl.clear  = done_blk;
      crc_ctl.enable = accept || (state_ff == ST_PAD);
      crc_ctl.data   = (state_ff == ST_PAD) ? crcbp_pkg::PAD_BYTE : req_tdata;
   end

   crcbp_crc u_crc (
      .clock (clock),
      .reset (reset),
      .ctl   (crc_ctl),
      .crc   (crc_value)
   );

   crcbp_store #(
      .WORD_COUNT (WORD_COUNT),
      .WA_W       (WA_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (WA_W'(fill_ff >> crcbp_pkg::LANE_W)),
      .wr_lane (fill_ff[crcbp_pkg::LANE_W-1:0]),
      .wr_data (req_tdata),
      .rd_en   (issue_rd),
      .rd_addr (rd_cnt_ff[WA_W-1:0]),
      .rd_data (rd_data)
   );

   // Bytes at or beyond the fill count belong to the padding and read as 0xFF.
   always_comb begin
      word_masked = rd_data;
      for (int i = 0; i < 8; i++) begin
         if (32'({ld_cnt_ff, crcbp_pkg::LANE_W'(i)}) >= 32'(fill_ff)) begin
            word_masked[i*crcbp_pkg::BYTE_W +: crcbp_pkg::BYTE_W] = crcbp_pkg::PAD_BYTE;
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      pad_in      = pad_ff;
      addr_in     = addr_ff;
      last_in     = last_ff;
      hdr_pend_in = hdr_pend_ff;
      rd_cnt_in   = rd_cnt_ff;
      ld_cnt_in   = ld_cnt_ff;
      rd_valid_in = rd_valid_ff;

      unique case (state_ff)
         ST_FILL: begin
            if (accept) begin
               fill_in = fill_inc;
               if ((fill_inc == FILL_W'(BLOCK_BYTES)) || req_tlast) begin
                  last_in     = req_tlast;
                  pad_in      = fill_inc;
                  hdr_pend_in = 1'b1;
                  rd_cnt_in   = '0;
                  ld_cnt_in   = '0;
                  rd_valid_in = 1'b0;
                  state_in    = (fill_inc == FILL_W'(BLOCK_BYTES)) ? ST_EMIT : ST_PAD;
               end
            end
         end
         ST_PAD: begin
            pad_in = pad_ff + FILL_W'(1);
            if (pad_in == FILL_W'(BLOCK_BYTES)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load_hdr) begin
               hdr_pend_in = 1'b0;
            end
            if (issue_rd) begin
               rd_cnt_in   = rd_cnt_ff + WC_W'(1);
               rd_valid_in = 1'b1;
            end else if (load_word) begin
               rd_valid_in = 1'b0;
            end
            if (load_word) begin
               ld_cnt_in = ld_cnt_ff + WC_W'(1);
            end
            if (done_blk) begin
               fill_in  = '0;
               addr_in  = last_ff ? '0 : addr_ff + ADDR_BITS'(BLOCK_BYTES);
               state_in = ST_FILL;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_hdr_in   = rsp_hdr_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_crc_in   = rsp_crc_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_done_in  = rsp_done_ff;
      if (load_hdr) begin
         rsp_valid_in = 1'b1;
         rsp_hdr_in   = 1'b1;
         rsp_addr_in  = addr_ext[crcbp_pkg::OUT_ADDR_W-1:0];
         rsp_crc_in   = crc_value;
         rsp_word_in  = '0;
         rsp_end_in   = 1'b0;
         rsp_done_in  = 1'b0;
      end else if (load_word) begin
         rsp_valid_in = 1'b1;
         rsp_hdr_in   = 1'b0;
         rsp_addr_in  = '0;
         rsp_crc_in   = '0;
         rsp_word_in  = word_masked;
         rsp_end_in   = last_word;
         rsp_done_in  = last_word && last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_ff      <= '0;
         pad_ff       <= '0;
         addr_ff      <= '0;
         last_ff      <= 1'b0;
         hdr_pend_ff  <= 1'b0;
         rd_cnt_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         ld_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pad_ff       <= pad_in;
         addr_ff      <= addr_in;
         last_ff      <= last_in;
         hdr_pend_ff  <= hdr_pend_in;
         rd_cnt_ff    <= rd_cnt_in;
         rd_valid_ff  <= rd_valid_in;
         ld_cnt_ff    <= ld_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hdr_ff  <= rsp_hdr_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_crc_ff  <= rsp_crc_in;
      rsp_word_ff <= rsp_word_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hdr_ff;
   assign rsp_tlast  = rsp_end_ff;
   assign rsp_tdata  = {{crcbp_pkg::RSP_PAD_W{1'b0}}, rsp_done_ff, rsp_word_ff,
                        rsp_crc_ff, rsp_addr_ff};

   `ASSERT_CLK(a_load_behind_read, ld_cnt_ff <= rd_cnt_ff, "word loaded before it was read")
   `ASSERT_CLK(a_pad_in_range, (state_ff == ST_PAD) |-> (pad_ff < FILL_W'(BLOCK_BYTES)), "pad count past block end")
   `ASSERT_CLK(a_crc_hold, ((state_ff == ST_EMIT) && $past(state_ff == ST_EMIT)) |-> $stable(crc_value), "crc changed during emit")
   `ASSERT_NEVER(a_emit_empty, (state_ff == ST_EMIT) && (fill_ff == '0), "emitting an empty block")

endmodule

// ----- hdl/crcbp_crc.sv -----
// ----------------------------------------------------------------------------
// crcbp_crc
// Running CRC-8 register, advanced by one byte per enabled cycle.
// ----------------------------------------------------------------------------
module crcbp_crc (
   input  logic                   clock,
   input  logic                   reset,
   input  crcbp_pkg::crc_ctl_type ctl,
   output logic [7:0]             crc
);

   logic [7:0] crc_ff;
   logic [7:0] crc_in;

   always_comb begin
      crc_in = crc_ff;
      if (ctl.clear) begin
         crc_in = '0;
      end else if (ctl.enable) begin
         crc_in = crcbp_pkg::crc8_byte(crc_ff, ctl.data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
      end else begin
         crc_ff <= crc_in;
      end
   end

   assign crc = crc_ff;

endmodule

// ----- hdl/crcbp_store.sv -----
// ----------------------------------------------------------------------------
// crcbp_store
// Block payload memory: byte-lane writes and 64-bit word reads through a
// registered read port.
// ----------------------------------------------------------------------------
module crcbp_store #(
   parameter int WORD_COUNT = 32,
   parameter int WA_W       = 5
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [WA_W-1:0]              wr_addr,
   input  logic [crcbp_pkg::LANE_W-1:0] wr_lane,
   input  logic [7:0]                   wr_data,
   input  logic                         rd_en,
   input  logic [WA_W-1:0]              rd_addr,
   output logic [crcbp_pkg::WORD_W-1:0] rd_data
);

   logic [crcbp_pkg::WORD_W-1:0] store_mem [WORD_COUNT];
   logic [crcbp_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr][wr_lane*crcbp_pkg::BYTE_W +: crcbp_pkg::BYTE_W] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- bench/crc8_block_packetizer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc8_block_packetizer_tb
// Self-checking bench for the CRC-8 block framer.
// ----------------------------------------------------------------------------
// Firmware images of assorted lengths are streamed in as bytes. Short images
// exercise the 0xFF padding, and a longer one gives a full block, an address
// step and a short tail. A scoreboard rebuilds every block, its CRC and its
// data words, and compares each result item field by field. Both handshakes
// idle at random. At the start the receiver holds off for a long stretch so
// the block stalls.
// ----------------------------------------------------------------------------

typedef struct {
   bit        hdr;
   bit [23:0] addr;
   bit [7:0]  crc;
   bit [63:0] word;
   bit        pkt_end;
   bit        img_done;
} block_beat_type;

class block_framer_scoreboard;

   localparam int        BLOCK_LEN  = 256;
   localparam int        WORDS      = BLOCK_LEN / 8;
   localparam bit [23:0] BLOCK_STEP = 24'(BLOCK_LEN);

   bit [7:0]       block_bytes [BLOCK_LEN];
   int             fill;
   bit [23:0]      block_addr;
   bit [7:0]       crc_acc;
   block_beat_type awaited_beats[$];
   int             failures;

   function new();
      fill       = 0;
      block_addr = '0;
      crc_acc    = '0;
      failures   = 0;
   endfunction

   // Bit-serial CRC-8, data shifted in MSB first.
   function bit [7:0] crc8_next(bit [7:0] acc, bit [7:0] din);
      bit [7:0] r;
      bit       fb;
      r = acc;
      for (int i = 7; i >= 0; i--) begin
         fb = r[7] ^ din[i];
         r  = {r[6:0], 1'b0};
         if (fb) begin
            r = r ^ crcbp_pkg::CRC_POLY;
         end
      end
      return r;
   endfunction

   // Takes one image byte and queues the packet it closes, if any.
   function void note_input(bit [7:0] din, bit img_end);
      block_beat_type beat;
      block_bytes[fill] = din;
      crc_acc = crc8_next(crc_acc, din);
      fill++;
      if (fill < BLOCK_LEN && !img_end) begin
         return;
      end
      for (int i = fill; i < BLOCK_LEN; i++) begin
         block_bytes[i] = crcbp_pkg::PAD_BYTE;
         crc_acc = crc8_next(crc_acc, crcbp_pkg::PAD_BYTE);
      end
      beat = '{hdr: 1'b1, addr: block_addr, crc: crc_acc, word: '0,
               pkt_end: 1'b0, img_done: 1'b0};
      awaited_beats.push_back(beat);
      for (int w = 0; w < WORDS; w++) begin
         beat = '{hdr: 1'b0, addr: '0, crc: '0, word: '0,
                  pkt_end: (w == WORDS - 1), img_done: (w == WORDS - 1) && img_end};
         for (int k = 0; k < 8; k++) begin
            beat.word[8*k +: 8] = block_bytes[8*w + k];
         end
         awaited_beats.push_back(beat);
      end
      fill    = 0;
      crc_acc = '0;
      block_addr = img_end ? 24'd0 : block_addr + BLOCK_STEP;
   endfunction

   function void compare_field(string name, logic [63:0] exp, logic [63:0] act);
      if (act !== exp) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, act);
         failures++;
      end
   endfunction

   function void check_result(logic [crcbp_pkg::RSP_DATA_W-1:0] tdata, logic tuser,
                              logic tlast);
      block_beat_type exp;
      if (awaited_beats.size() == 0) begin
         $display("%0t: result item with nothing expected, expected none, got %h",
                  $time, tdata);
         failures++;
         return;
      end
      exp = awaited_beats.pop_front();
      compare_field("is_header", exp.hdr, tuser);
      compare_field("block_address", exp.addr, tdata[23:0]);
      compare_field("block_crc", exp.crc, tdata[31:24]);
      compare_field("payload_word", exp.word, tdata[95:32]);
      compare_field("image_done", exp.img_done, tdata[96]);
      compare_field("zero fill", '0, tdata[103:97]);
      compare_field("packet_end", exp.pkt_end, tlast);
   endfunction

   function int pending();
      return awaited_beats.size();
   endfunction

endclass

module crc8_block_packetizer_tb;

   localparam int BLOCK_LEN     = 256;
   localparam int HOLD_CYCLES   = 700;
   localparam int TAIL_CYCLES   = BLOCK_LEN + 64;
   localparam int STALL_LIMIT   = 5000;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [7:0]                       req_tdata;   // image_byte
   logic                             req_tlast;   // image_end
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   // block_address [23:0], block_crc [31:24], payload_word [95:32],
   // image_done [96], zero fill [103:97]
   logic [crcbp_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                             rsp_tuser;   // is_header
   logic                             rsp_tlast;   // packet_end

   block_framer_scoreboard blocks;
   bit                     src_calm;

   crc8_block_packetizer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int src_gap();
      int r;
      if (src_calm) begin
         return 0;
      end
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(3, 1);
      if (r < 98) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic bit [7:0] image_value();
      int r;
      r = $urandom_range(99);
      if (r < 8) return 8'h00;
      if (r < 16) return 8'hFF;
      return 8'($urandom);
   endfunction

   // The expectation is formed when the item is offered; the item is then
   // held unchanged until the block accepts it, so the order is kept.
   task automatic send_item(input bit [7:0] din, input bit img_end);
      int gap;
      gap = src_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= din;
      req_tlast  <= img_end;
      req_tvalid <= 1'b1;
      blocks.note_input(din, img_end);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_image(input int len);
      src_calm = ($urandom_range(3) == 0);
      for (int i = 0; i < len; i++) begin
         send_item(image_value(), i == len - 1);
      end
   endtask

   // Receiver: one long hold-off right after reset, then random stalls with
   // calm stretches now and then.
   initial begin
      int  stall;
      int  toggle_in;
      bit  calm;
      bit  ready;
      rsp_tready = 1'b0;
      stall     = 0;
      toggle_in = 150;
      calm      = 1'b0;
      wait (reset === 1'b0);
      repeat (HOLD_CYCLES) @(negedge clock);
      forever begin
         @(negedge clock);
         toggle_in--;
         if (toggle_in == 0) begin
            toggle_in = 150;
            calm = ($urandom_range(9) < 3);
         end
         if (stall > 0) begin
            stall--;
            ready = 1'b0;
         end else begin
            ready = 1'b1;
            if (!calm && $urandom_range(99) < 20) begin
               if ($urandom_range(99) < 70) stall = $urandom_range(2, 1);
               else if ($urandom_range(99) < 90) stall = $urandom_range(10, 3);
               else stall = $urandom_range(150, 30);
            end
         end
         rsp_tready <= ready;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         blocks.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   initial begin
      int idle_count;
      idle_count = 0;
      while (idle_count < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_count = 0;
         end else begin
            idle_count++;
         end
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      blocks     = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      src_calm   = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Single-byte images pad almost the whole block.
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b1);
      // Exactly one word, then one byte into the second word.
      for (int i = 0; i < 8; i++) send_item(8'(i * 8'h25), i == 7);
      for (int i = 0; i < 9; i++) send_item((i % 2) ? 8'hAA : 8'h55, i == 8);
      // A full block, then a one-byte tail at the next block address.
      send_image(BLOCK_LEN + 1);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (blocks.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (blocks.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- crc8_block_packetizer.f -----
+incdir+hdl
hdl/crcbp_pkg.sv
hdl/crcbp_crc.sv
hdl/crcbp_store.sv
hdl/crc8_block_packetizer.sv
bench/crc8_block_packetizer_tb.sv
